// ===== hdl/hptc_pkg.sv =====
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared widths, codes, reset values and stage records of the heading PID
// turn controller.
// ----------------------------------------------------------------------------
package hptc_pkg;

    localparam int ANGLE_W = 13;
    localparam int GAIN_W  = 28;
    localparam int TIME_W  = 16;
    localparam int STEP_W  = 8;
    localparam int INTEG_W = 32;
    localparam int POWER_W = 12;
    localparam int PHASE_W = 2;
    localparam int CIDX_W  = 3;

    localparam int PROD_P_W = ANGLE_W + GAIN_W;        // err * gain_p
    localparam int PROD_I_W = INTEG_W + GAIN_W;        // integral * gain_i
    localparam int PROD_D_W = ANGLE_W + 1 + GAIN_W;    // deriv * gain_d, signed
    localparam int SUM_W    = PROD_I_W + 2;
    localparam int FRAC_W   = 24;
    localparam int QUOT_W   = SUM_W - FRAC_W;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 13'd5760;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 13'd5759;

    localparam logic signed [QUOT_W-1:0]  POWER_POS = QUOT_W'(1600);
    localparam logic signed [QUOT_W-1:0]  POWER_NEG = -QUOT_W'(1600);
    localparam logic signed [SUM_W-1:0]   ROUND_BIAS = SUM_W'(1) << (FRAC_W - 1);

    // input command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // turn phase / status codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TURNING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REACHED = 2'd2;
    localparam logic [PHASE_W-1:0] PH_TIMEOUT = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_TARGET  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GAIN_P  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_GAIN_I  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_GAIN_D  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TOL     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT = 3'd5;

    localparam logic [ANGLE_W-1:0] RST_TARGET  = 13'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P  = 28'd6710886;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I  = 28'd168;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D  = 28'd10066330;
    localparam logic [ANGLE_W-1:0] RST_TOL     = 13'd32;
    localparam logic [TIME_W-1:0]  RST_TIMEOUT = 16'd2000;

    typedef struct packed {
        logic [ANGLE_W-1:0] target;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [ANGLE_W-1:0] tolerance;
        logic [TIME_W-1:0]  timeout;
    } t_cfg;

    // error stage -> multiply stage
    typedef struct packed {
        logic [ANGLE_W-1:0]        err;
        logic signed [ANGLE_W:0]   deriv;
        logic [INTEG_W-1:0]        integ;
        logic                      cw;
        logic                      drive;
        logic [PHASE_W-1:0]        status;
    } t_trk;

    // multiply stage -> sum stage
    typedef struct packed {
        logic [PROD_P_W-1:0]        prod_p;
        logic [PROD_I_W-1:0]        prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       cw;
        logic                       drive;
        logic [PHASE_W-1:0]         status;
    } t_prd;

endpackage

// ===== hdl/heading_pid_turn_controller_unit.sv =====
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_unit
// PID heading controller for an in-place turn with angle wrap, opposite
// saturated drive powers and reached / timeout detection.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      word
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//  s_axis    in         s_axis_tvalid / s_axis_tready  heading, step_ms; tuser command
//  m_axis    out        m_axis_tvalid / m_axis_tready  left, right power; tuser status
//
//  One word per cycle sustained while m_axis_tready is held. A result passes
//  through the input register, error stage, gain multipliers, sum and output
//  register. Turn state is updated in the error stage, so back-to-back samples
//  see each other's integral and error. Each stage holds under a stall and an
//  empty stage still takes a word. Synchronous reset restores registers to
//  their defaults and the phase to idle; cfg writes are always ready.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hptc_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [hptc_pkg::GAIN_W-1:0]         i_cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,   // heading[12:0], step_ms[20:13]
    input  logic                                s_axis_tuser,   // command[0]

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // left[11:0], right[23:12]
    output logic [hptc_pkg::PHASE_W-1:0]        m_axis_tuser    // status[1:0]
);

    hptc_pkg::t_cfg                         cfg;
    hptc_pkg::t_trk                         trk;
    hptc_pkg::t_prd                         prd;
    logic                                   trk_valid, trk_ready;
    logic                                   prd_valid, prd_ready;
    logic signed [hptc_pkg::POWER_W-1:0]    left, right;

    assign o_cfg_ready = 1'b1;

    hptc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hptc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_head  (s_axis_tdata[12:0]),
        .i_step  (s_axis_tdata[20:13]),
        .o_valid (trk_valid),
        .i_ready (trk_ready),
        .o_trk   (trk)
    );

    hptc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (trk_valid),
        .o_ready (trk_ready),
        .i_trk   (trk),
        .o_valid (prd_valid),
        .i_ready (prd_ready),
        .o_prd   (prd)
    );

    hptc_sat u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prd_valid),
        .o_ready  (prd_ready),
        .i_prd    (prd),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_left   (left),
        .o_right  (right),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = {right, left};

endmodule

// ===== hdl/hptc_cfg.sv =====
// ----------------------------------------------------------------------------
// hptc_cfg
// Configuration register file: target, PID gains, tolerance and timeout.
// ----------------------------------------------------------------------------
module hptc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [hptc_pkg::CIDX_W-1:0]     i_index,
    input  logic [hptc_pkg::GAIN_W-1:0]     i_data,
    output hptc_pkg::t_cfg                  o_cfg
);

    hptc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target    <= hptc_pkg::RST_TARGET;
            r_cfg.gain_p    <= hptc_pkg::RST_GAIN_P;
            r_cfg.gain_i    <= hptc_pkg::RST_GAIN_I;
            r_cfg.gain_d    <= hptc_pkg::RST_GAIN_D;
            r_cfg.tolerance <= hptc_pkg::RST_TOL;
            r_cfg.timeout   <= hptc_pkg::RST_TIMEOUT;
        end else if (i_wr) begin
            case (i_index)
                hptc_pkg::REG_TARGET:  r_cfg.target    <= i_data[hptc_pkg::ANGLE_W-1:0];
                hptc_pkg::REG_GAIN_P:  r_cfg.gain_p    <= i_data;
                hptc_pkg::REG_GAIN_I:  r_cfg.gain_i    <= i_data;
                hptc_pkg::REG_GAIN_D:  r_cfg.gain_d    <= i_data;
                hptc_pkg::REG_TOL:     r_cfg.tolerance <= i_data[hptc_pkg::ANGLE_W-1:0];
                hptc_pkg::REG_TIMEOUT: r_cfg.timeout   <= i_data[hptc_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/hptc_track.sv =====
// ----------------------------------------------------------------------------
// hptc_track
// Input register, turn state and error stage: wrapped error, direction,
// stop checks, integral and derivative terms.
// ----------------------------------------------------------------------------
module hptc_track (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hptc_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic [hptc_pkg::ANGLE_W-1:0]    i_head,
    input  logic [hptc_pkg::STEP_W-1:0]     i_step,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hptc_pkg::t_trk                  o_trk
);

    // input register
    logic                           r_a_vld;
    logic                           r_a_cmd;
    logic [hptc_pkg::ANGLE_W-1:0]   r_a_head;
    logic [hptc_pkg::STEP_W-1:0]    r_a_step;

    // turn state
    logic [hptc_pkg::INTEG_W-1:0]   r_integ, n_integ;
    logic [hptc_pkg::ANGLE_W-1:0]   r_prev, n_prev;
    logic [hptc_pkg::TIME_W-1:0]    r_elapsed, n_elapsed;
    logic [hptc_pkg::PHASE_W-1:0]   r_phase, n_phase;

    // stage register
    logic                           r_b_vld;
    hptc_pkg::t_trk                 r_b, n_b;

    logic                           a_ready, b_ready;
    logic [hptc_pkg::ANGLE_W-1:0]   head, tgt, diff, err_cw, err_ccw, err;
    logic [hptc_pkg::TIME_W:0]      elap_sum;
    logic [hptc_pkg::TIME_W-1:0]    elap_sat;
    logic [hptc_pkg::INTEG_W:0]     integ_sum;
    logic [hptc_pkg::INTEG_W-1:0]   integ_upd;
    logic                           cw, reached, timed_out;

    assign b_ready = !r_b_vld || i_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        head = (r_a_head >= hptc_pkg::ANGLE_FULL) ? hptc_pkg::ANGLE_MAX : r_a_head;
        tgt  = (i_cfg.target >= hptc_pkg::ANGLE_FULL) ? hptc_pkg::ANGLE_MAX : i_cfg.target;

        diff    = (tgt >= head) ? tgt - head : head - tgt;
        reached = diff <= i_cfg.tolerance;

        elap_sum  = {1'b0, r_elapsed} + (hptc_pkg::TIME_W+1)'(r_a_step);
        elap_sat  = elap_sum[hptc_pkg::TIME_W] ? '1 : elap_sum[hptc_pkg::TIME_W-1:0];
        timed_out = elap_sat >= i_cfg.timeout;

        // going the long way round wraps through zero
        err_cw  = (tgt >= head) ? tgt - head : hptc_pkg::ANGLE_FULL - (head - tgt);
        err_ccw = (tgt > head) ? hptc_pkg::ANGLE_FULL - (tgt - head) : head - tgt;
        cw      = err_cw < err_ccw;
        err     = cw ? err_cw : err_ccw;

        integ_sum = {1'b0, r_integ} + (hptc_pkg::INTEG_W+1)'(err);
        integ_upd = integ_sum[hptc_pkg::INTEG_W] ? '1 : integ_sum[hptc_pkg::INTEG_W-1:0];
        if (err == '0 || err > tgt) begin
            integ_upd = '0;
        end

        n_integ   = r_integ;
        n_prev    = r_prev;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;

        n_b.err    = err;
        n_b.deriv  = $signed({1'b0, err}) - $signed({1'b0, r_prev});
        n_b.integ  = integ_upd;
        n_b.cw     = cw;
        n_b.drive  = 1'b0;
        n_b.status = r_phase;

        if (r_a_cmd == hptc_pkg::CMD_START) begin
            n_integ    = '0;
            n_prev     = '0;
            n_elapsed  = '0;
            n_phase    = hptc_pkg::PH_TURNING;
            n_b.status = hptc_pkg::PH_TURNING;
        end else if (r_phase == hptc_pkg::PH_TURNING) begin
            n_elapsed = elap_sat;
            if (reached) begin
                n_phase    = hptc_pkg::PH_REACHED;
                n_b.status = hptc_pkg::PH_REACHED;
            end else if (timed_out) begin
                n_phase    = hptc_pkg::PH_TIMEOUT;
                n_b.status = hptc_pkg::PH_TIMEOUT;
            end else begin
                n_integ   = integ_upd;
                n_prev    = err;
                n_b.drive = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_integ   <= '0;
            r_prev    <= '0;
            r_elapsed <= '0;
            r_phase   <= hptc_pkg::PH_IDLE;
        end else begin
            if (a_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
            if (r_a_vld && b_ready) begin
                r_integ   <= n_integ;
                r_prev    <= n_prev;
                r_elapsed <= n_elapsed;
                r_phase   <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_cmd  <= i_cmd;
            r_a_head <= i_head;
            r_a_step <= i_step;
        end
        if (b_ready) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_vld;
    assign o_trk   = r_b;

endmodule

// ===== hdl/hptc_mult.sv =====
// ----------------------------------------------------------------------------
// hptc_mult
// Gain stage: the three PID products, each in a multiplier of its own.
// ----------------------------------------------------------------------------
module hptc_mult (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hptc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  hptc_pkg::t_trk      i_trk,
    output logic                o_valid,
    input  logic                i_ready,
    output hptc_pkg::t_prd      o_prd
);

    logic               r_vld;
    hptc_pkg::t_prd     r_prd, n_prd;
    logic               c_ready;

    assign c_ready = !r_vld || i_ready;
    assign o_ready = c_ready;

    always_comb begin
        n_prd.prod_p = hptc_pkg::PROD_P_W'(i_trk.err) * hptc_pkg::PROD_P_W'(i_cfg.gain_p);
        n_prd.prod_i = hptc_pkg::PROD_I_W'(i_trk.integ) * hptc_pkg::PROD_I_W'(i_cfg.gain_i);
        n_prd.prod_d = hptc_pkg::PROD_D_W'(i_trk.deriv)
                     * $signed({{(hptc_pkg::PROD_D_W-hptc_pkg::GAIN_W){1'b0}}, i_cfg.gain_d});
        n_prd.cw     = i_trk.cw;
        n_prd.drive  = i_trk.drive;
        n_prd.status = i_trk.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (c_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready) begin
            r_prd <= n_prd;
        end
    end

    assign o_valid = r_vld;
    assign o_prd   = r_prd;

endmodule

// ===== hdl/hptc_sat.sv =====
// ----------------------------------------------------------------------------
// hptc_sat
// Sum stage and output register: adds the PID terms with the rounding bias,
// scales out of Q24, saturates and steers the power to the two sides.
// ----------------------------------------------------------------------------
module hptc_sat (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hptc_pkg::t_prd                      i_prd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [hptc_pkg::POWER_W-1:0] o_left,
    output logic signed [hptc_pkg::POWER_W-1:0] o_right,
    output logic [hptc_pkg::PHASE_W-1:0]        o_status
);

    logic                                   r_d_vld;
    logic signed [hptc_pkg::SUM_W-1:0]      r_d_sum, n_d_sum;
    logic                                   r_d_cw, r_d_drive;
    logic [hptc_pkg::PHASE_W-1:0]           r_d_status;

    logic                                   r_e_vld;
    logic signed [hptc_pkg::POWER_W-1:0]    r_left, r_right, n_left, n_right;
    logic [hptc_pkg::PHASE_W-1:0]           r_status;

    logic                                   d_ready, e_ready;
    logic signed [hptc_pkg::QUOT_W-1:0]     quot;
    logic signed [hptc_pkg::POWER_W-1:0]    pwr;

    assign e_ready = !r_e_vld || i_ready;
    assign d_ready = !r_d_vld || e_ready;
    assign o_ready = d_ready;

    assign n_d_sum = $signed(hptc_pkg::SUM_W'(i_prd.prod_p))
                   + $signed(hptc_pkg::SUM_W'(i_prd.prod_i))
                   + hptc_pkg::SUM_W'(i_prd.prod_d)
                   + hptc_pkg::ROUND_BIAS;

    always_comb begin
        // floor of biased sum: round to nearest, ties up
        quot = r_d_sum[hptc_pkg::SUM_W-1:hptc_pkg::FRAC_W];
        if (quot > hptc_pkg::POWER_POS) begin
            pwr = hptc_pkg::POWER_W'(hptc_pkg::POWER_POS);
        end else if (quot < hptc_pkg::POWER_NEG) begin
            pwr = hptc_pkg::POWER_W'(hptc_pkg::POWER_NEG);
        end else begin
            pwr = quot[hptc_pkg::POWER_W-1:0];
        end
        if (!r_d_drive) begin
            n_left  = '0;
            n_right = '0;
        end else if (r_d_cw) begin
            n_left  = pwr;
            n_right = -pwr;
        end else begin
            n_left  = -pwr;
            n_right = pwr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (d_ready) begin
                r_d_vld <= i_valid;
            end
            if (e_ready) begin
                r_e_vld <= r_d_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready) begin
            r_d_sum    <= n_d_sum;
            r_d_cw     <= i_prd.cw;
            r_d_drive  <= i_prd.drive;
            r_d_status <= i_prd.status;
        end
        if (e_ready) begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_status <= r_d_status;
        end
    end

    assign o_valid  = r_e_vld;
    assign o_left   = r_left;
    assign o_right  = r_right;
    assign o_status = r_status;

endmodule

// ===== tb/tb_heading_pid_turn_controller_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heading_pid_turn_controller_unit
// Self-checking bench for the heading PID turn controller. A directed table
// covers reset state, angle wrap, ties, out-of-range angles, reached and
// timeout stops. It is followed by random turns under several register
// settings. Every output word is checked against a typed value or an in-bench
// model of the controller, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_heading_pid_turn_controller_unit;

    typedef struct packed {
        logic [hptc_pkg::POWER_W-1:0] left;
        logic [hptc_pkg::POWER_W-1:0] right;
        logic [hptc_pkg::PHASE_W-1:0] status;
    } t_drive;

    typedef struct packed {
        logic                         cmd;
        logic [hptc_pkg::ANGLE_W-1:0] head;
        logic [hptc_pkg::STEP_W-1:0]  step;
        logic                         typed;
        t_drive                       want;
    } t_dir_row;

    localparam t_drive IDLE_OUT  = {12'd0, 12'd0, hptc_pkg::PH_IDLE};
    localparam t_drive TURN_OUT  = {12'd0, 12'd0, hptc_pkg::PH_TURNING};
    localparam t_drive REACH_OUT = {12'd0, 12'd0, hptc_pkg::PH_REACHED};
    localparam t_drive TMO_OUT   = {12'd0, 12'd0, hptc_pkg::PH_TIMEOUT};

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam logic [hptc_pkg::CIDX_W-1:0] REG_SPARE = 3'd6;
    localparam logic [hptc_pkg::GAIN_W-1:0] GAIN_TOP  = 28'hFFFFFFF;
    localparam int POWER_CAP      = 1600;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 7;
    localparam int TURN_WORDS     = 38;

    // directed words, reset register values (target 0, tolerance 32, timeout 2000)
    localparam t_dir_row DIR_ROWS [23] = '{
        // sample before any start
        {hptc_pkg::CMD_SAMPLE, 13'd0,    8'd0,   TYPED,     IDLE_OUT},
        // start ignores its step
        {hptc_pkg::CMD_START,  13'd8191, 8'd255, TYPED,     TURN_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd5759, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd8191, 8'd255, PREDICTED, IDLE_OUT},
        // equal wrapped errors
        {hptc_pkg::CMD_SAMPLE, 13'd2880, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd2881, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd2879, 8'd255, PREDICTED, IDLE_OUT},
        // just outside tolerance
        {hptc_pkg::CMD_SAMPLE, 13'd33,   8'd255, PREDICTED, IDLE_OUT},
        // close only after wrap
        {hptc_pkg::CMD_SAMPLE, 13'd5750, 8'd255, PREDICTED, IDLE_OUT},
        // in band and past timeout
        {hptc_pkg::CMD_SAMPLE, 13'd16,   8'd255, TYPED,     REACH_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd3000, 8'd0,   TYPED,     REACH_OUT},
        {hptc_pkg::CMD_START,  13'd0,    8'd0,   TYPED,     TURN_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd4000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd1000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd1000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd5000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd100,  8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd6000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd3000, 8'd255, PREDICTED, IDLE_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd3000, 8'd255, TYPED,     TMO_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd0,    8'd0,   TYPED,     TMO_OUT},
        {hptc_pkg::CMD_START,  13'd5000, 8'd0,   TYPED,     TURN_OUT},
        {hptc_pkg::CMD_SAMPLE, 13'd0,    8'd0,   TYPED,     REACH_OUT}
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [hptc_pkg::CIDX_W-1:0]  i_cfg_index = '0;
    logic [hptc_pkg::GAIN_W-1:0]  i_cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [23:0]                  s_axis_tdata = '0;     // heading[12:0], step_ms[20:13]
    logic                         s_axis_tuser = 1'b0;   // command[0]
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [23:0]                  m_axis_tdata;          // left[11:0], right[23:12]
    logic [hptc_pkg::PHASE_W-1:0] m_axis_tuser;          // status[1:0]

    // model state and register copy
    hptc_pkg::t_cfg               cfg = {hptc_pkg::RST_TARGET, hptc_pkg::RST_GAIN_P,
                                         hptc_pkg::RST_GAIN_I, hptc_pkg::RST_GAIN_D,
                                         hptc_pkg::RST_TOL, hptc_pkg::RST_TIMEOUT};
    logic [hptc_pkg::INTEG_W-1:0] integ_acc = '0;
    int                           last_err = 0;
    logic [hptc_pkg::TIME_W-1:0]  elapsed_ms = '0;
    logic [hptc_pkg::PHASE_W-1:0] turn_phase_q = hptc_pkg::PH_IDLE;

    t_drive drive_expected [$];
    t_drive want;
    t_drive got;
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;
    bit     rx_hold_req = 1'b0;
    int     rx_hold_left = 0;

    heading_pid_turn_controller_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // power and status for one accepted word; updates the turn state
    function automatic t_drive turn_response(logic cmd,
                                             logic [hptc_pkg::ANGLE_W-1:0] head_raw,
                                             logic [hptc_pkg::STEP_W-1:0] step);
        int                           head, tgt, diff, err_cw, err_ccw, err;
        bit                           cw;
        longint                       acc;
        logic [hptc_pkg::TIME_W:0]    el_sum;
        logic [hptc_pkg::INTEG_W:0]   integ_sum;
        t_drive                       res;
        res  = IDLE_OUT;
        head = (head_raw > hptc_pkg::ANGLE_MAX) ? int'(hptc_pkg::ANGLE_MAX) : int'(head_raw);
        tgt  = (cfg.target > hptc_pkg::ANGLE_MAX) ? int'(hptc_pkg::ANGLE_MAX)
                                                  : int'(cfg.target);
        if (cmd == hptc_pkg::CMD_START) begin
            integ_acc    = '0;
            last_err     = 0;
            elapsed_ms   = '0;
            turn_phase_q = hptc_pkg::PH_TURNING;
            return TURN_OUT;
        end
        if (turn_phase_q != hptc_pkg::PH_TURNING) begin
            res.status = turn_phase_q;
            return res;
        end
        el_sum     = elapsed_ms + step;
        elapsed_ms = el_sum[hptc_pkg::TIME_W] ? '1 : el_sum[hptc_pkg::TIME_W-1:0];
        // completion uses the plain difference, no wrap
        diff = (tgt >= head) ? tgt - head : head - tgt;
        if (diff <= int'(cfg.tolerance)) begin
            turn_phase_q = hptc_pkg::PH_REACHED;
            return REACH_OUT;
        end
        if (elapsed_ms >= cfg.timeout) begin
            turn_phase_q = hptc_pkg::PH_TIMEOUT;
            return TMO_OUT;
        end
        err_cw  = (tgt >= head) ? tgt - head : int'(hptc_pkg::ANGLE_FULL) - head + tgt;
        err_ccw = (tgt > head) ? int'(hptc_pkg::ANGLE_FULL) + head - tgt : head - tgt;
        cw      = err_cw < err_ccw;
        err     = cw ? err_cw : err_ccw;
        integ_sum = integ_acc + 33'(err);
        integ_acc = integ_sum[hptc_pkg::INTEG_W] ? '1 : integ_sum[hptc_pkg::INTEG_W-1:0];
        if (err == 0 || err > tgt)
            integ_acc = '0;
        acc = longint'(err) * longint'(cfg.gain_p)
            + longint'(integ_acc) * longint'(cfg.gain_i)
            + longint'(err - last_err) * longint'(cfg.gain_d);
        acc = (acc + (longint'(1) <<< 23)) >>> 24;
        if (acc > POWER_CAP)
            acc = POWER_CAP;
        if (acc < -POWER_CAP)
            acc = -POWER_CAP;
        last_err   = err;
        res.left   = cw ? 12'(acc) : 12'(-acc);
        res.right  = cw ? 12'(-acc) : 12'(acc);
        res.status = hptc_pkg::PH_TURNING;
        return res;
    endfunction

    // entered and left at a falling edge
    task automatic offer_word(logic cmd, logic [hptc_pkg::ANGLE_W-1:0] head,
                              logic [hptc_pkg::STEP_W-1:0] step,
                              logic typed, t_drive typed_want);
        t_drive modeled;
        while (!calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, step, head};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        modeled = turn_response(cmd, head, step);
        drive_expected.push_back(typed ? typed_want : modeled);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [hptc_pkg::CIDX_W-1:0] idx,
                             logic [hptc_pkg::GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            hptc_pkg::REG_TARGET:  cfg.target    = val[hptc_pkg::ANGLE_W-1:0];
            hptc_pkg::REG_GAIN_P:  cfg.gain_p    = val;
            hptc_pkg::REG_GAIN_I:  cfg.gain_i    = val;
            hptc_pkg::REG_GAIN_D:  cfg.gain_d    = val;
            hptc_pkg::REG_TOL:     cfg.tolerance = val[hptc_pkg::ANGLE_W-1:0];
            hptc_pkg::REG_TIMEOUT: cfg.timeout   = val[hptc_pkg::TIME_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // stop offering and wait out every pending word plus pipeline latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (drive_expected.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic load_setting(int ph);
        case (ph)
            0: begin
                write_reg(hptc_pkg::REG_TARGET, GAIN_TOP);  // masks to 8191, clamps to 5759
                write_reg(hptc_pkg::REG_GAIN_P, GAIN_TOP);
                write_reg(hptc_pkg::REG_GAIN_I, GAIN_TOP);
                write_reg(hptc_pkg::REG_GAIN_D, GAIN_TOP);
                write_reg(hptc_pkg::REG_TOL, 28'd0);
                write_reg(hptc_pkg::REG_TIMEOUT, GAIN_TOP);
                write_reg(REG_SPARE, 28'h5A5A5A5);
            end
            1: begin
                write_reg(hptc_pkg::REG_TARGET, 28'd0);
                write_reg(hptc_pkg::REG_GAIN_P, 28'd0);
                write_reg(hptc_pkg::REG_GAIN_I, 28'd0);
                write_reg(hptc_pkg::REG_GAIN_D, 28'd0);
                write_reg(hptc_pkg::REG_TOL, 28'd0);
                write_reg(hptc_pkg::REG_TIMEOUT, 28'd0);
            end
            2: begin
                write_reg(hptc_pkg::REG_TARGET, 28'(hptc_pkg::ANGLE_MAX));
                write_reg(hptc_pkg::REG_GAIN_P, hptc_pkg::RST_GAIN_P);
                write_reg(hptc_pkg::REG_GAIN_I, hptc_pkg::RST_GAIN_I);
                write_reg(hptc_pkg::REG_GAIN_D, hptc_pkg::RST_GAIN_D);
                write_reg(hptc_pkg::REG_TOL, 28'h1FFF);
                write_reg(hptc_pkg::REG_TIMEOUT, 28'(hptc_pkg::RST_TIMEOUT));
            end
            default: begin
                write_reg(hptc_pkg::REG_TARGET,
                          28'(($urandom_range(9) == 0) ? $urandom_range(8191)
                                                       : $urandom_range(5759)));
                write_reg(hptc_pkg::REG_GAIN_P, ($urandom_range(4) == 0) ? GAIN_TOP
                                                : 28'($urandom_range(1 << 26)));
                write_reg(hptc_pkg::REG_GAIN_I, ($urandom_range(4) == 0) ? GAIN_TOP
                                                : 28'($urandom_range(1 << 14)));
                write_reg(hptc_pkg::REG_GAIN_D, ($urandom_range(4) == 0) ? GAIN_TOP
                                                : 28'($urandom_range(1 << 26)));
                write_reg(hptc_pkg::REG_TOL, 28'($urandom_range(200)));
                write_reg(hptc_pkg::REG_TIMEOUT, 28'($urandom_range(4000, 300)));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // partly near the target so that turns also finish in band
    function automatic logic [hptc_pkg::ANGLE_W-1:0] pick_heading();
        int tgt, off, pick;
        pick = $urandom_range(99);
        tgt  = (cfg.target > hptc_pkg::ANGLE_MAX) ? int'(hptc_pkg::ANGLE_MAX)
                                                  : int'(cfg.target);
        off  = $urandom_range((cfg.tolerance > 400) ? 416 : int'(cfg.tolerance) + 16);
        if (pick < 30)
            return 13'((tgt + ((pick < 15) ? off : int'(hptc_pkg::ANGLE_FULL) - off))
                       % int'(hptc_pkg::ANGLE_FULL));
        if (pick < 36)
            return 13'($urandom_range(8191, 5760));
        return 13'($urandom_range(5759));
    endfunction

    task automatic random_turns(int goal);
        int   counted;
        logic noise_cmd;
        counted = 0;
        while (counted < goal) begin
            if ($urandom_range(99) < 8) begin
                // stray word: sample outside a turn or a restart mid-turn
                noise_cmd = 1'($urandom_range(1));
                counted++;
                offer_word(noise_cmd, 13'($urandom_range(8191)), 8'($urandom_range(255)),
                           PREDICTED, IDLE_OUT);
            end else begin
                offer_word(hptc_pkg::CMD_START, 13'($urandom_range(8191)),
                           8'($urandom_range(255)), PREDICTED, IDLE_OUT);
                counted++;
                repeat ($urandom_range(20, 3)) begin
                    if (counted < goal) begin
                        counted++;
                        offer_word(hptc_pkg::CMD_SAMPLE, pick_heading(),
                                   $urandom_range(1) ? 8'($urandom_range(60))
                                                     : 8'($urandom_range(255)),
                                   PREDICTED, IDLE_OUT);
                    end
                end
            end
        end
    endtask

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: want left %0d right %0d status %0d, got left %0d right %0d status %0d",
                     what, $signed(want.left), $signed(want.right), want.status,
                     $signed(got.left), $signed(got.right), got.status);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tuser};
            if (drive_expected.size() == 0) begin
                want = IDLE_OUT;
                note_mismatch("unexpected word");
            end else begin
                want = drive_expected.pop_front();
                if (got.left !== want.left || got.right !== want.right
                        || got.status !== want.status)
                    note_mismatch("mismatch");
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("heading_pid_turn_controller_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[r])
            offer_word(DIR_ROWS[r].cmd, DIR_ROWS[r].head, DIR_ROWS[r].step,
                       DIR_ROWS[r].typed, DIR_ROWS[r].want);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            load_setting(ph);
            calm = (ph == 2);
            random_turns(TURN_WORDS);
            // output side stalls long while words keep coming
            if (ph == 3)
                rx_hold_req = 1'b1;
            random_turns(TURN_WORDS);
            drain();
        end

        if (mismatches == 0 && drive_expected.size() == 0)
            $display("heading_pid_turn_controller_unit regression: pass");
        else
            $display("heading_pid_turn_controller_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hptc_pkg.sv
hdl/hptc_cfg.sv
hdl/hptc_track.sv
hdl/hptc_mult.sv
hdl/hptc_sat.sv
hdl/heading_pid_turn_controller_unit.sv
tb/tb_heading_pid_turn_controller_unit.sv
